### rtl/assert_macros.svh
// Assertion macros used by the RTL of the text unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/xtu_pkg.sv
// Package with codes, constants and lookup tables of the XML text unescaper.
package xtu_pkg;

    // Parse modes.
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_ENTITY    = 3'd1;
    localparam logic [2:0] MODE_REF_HASH  = 3'd2;
    localparam logic [2:0] MODE_REF_DEC   = 3'd3;
    localparam logic [2:0] MODE_REF_HEX   = 3'd4;
    localparam logic [2:0] MODE_LOOKAHEAD = 3'd5;
    localparam logic [2:0] MODE_DONE      = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_BYTE      = 3'd0;
    localparam logic [2:0] ST_END       = 3'd1;
    localparam logic [2:0] ST_STRAY     = 3'd2;
    localparam logic [2:0] ST_BAD_ENT   = 3'd3;
    localparam logic [2:0] ST_BAD_REF   = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;
    localparam logic [2:0] ST_DATA_END  = 3'd6;

    localparam int          MAX_RES     = 12;
    localparam logic [7:0]  DELIM_RESET = 8'h3c;
    localparam logic [21:0] VALUE_LIMIT = 22'h200000;
    localparam int          CDATA_LEN   = 9;
    localparam int          NUM_ENT     = 5;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic [3:0] pushback;
        logic       last;
    } result_t;

    // Characters of the CDATA opening sequence.
    function automatic logic [7:0] cdata_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = "<";
            4'd1: c = "!";
            4'd2: c = "[";
            4'd3: c = "C";
            4'd4: c = "D";
            4'd5: c = "A";
            4'd6: c = "T";
            4'd7: c = "A";
            4'd8: c = "[";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Name length of each predefined entity, including the semicolon.
    function automatic logic [3:0] ent_len(input logic [2:0] k);
        logic [3:0] l;
        case (k)
            3'd0: l = 4'd3;
            3'd1: l = 4'd3;
            3'd2: l = 4'd4;
            3'd3: l = 4'd5;
            3'd4: l = 4'd5;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // Name characters of the predefined entities.
    function automatic logic [7:0] ent_name(input logic [2:0] k, input logic [2:0] p);
        logic [7:0] c;
        case ({k, p})
            {3'd0, 3'd0}: c = "l";
            {3'd0, 3'd1}: c = "t";
            {3'd0, 3'd2}: c = ";";
            {3'd1, 3'd0}: c = "g";
            {3'd1, 3'd1}: c = "t";
            {3'd1, 3'd2}: c = ";";
            {3'd2, 3'd0}: c = "a";
            {3'd2, 3'd1}: c = "m";
            {3'd2, 3'd2}: c = "p";
            {3'd2, 3'd3}: c = ";";
            {3'd3, 3'd0}: c = "a";
            {3'd3, 3'd1}: c = "p";
            {3'd3, 3'd2}: c = "o";
            {3'd3, 3'd3}: c = "s";
            {3'd3, 3'd4}: c = ";";
            {3'd4, 3'd0}: c = "q";
            {3'd4, 3'd1}: c = "u";
            {3'd4, 3'd2}: c = "o";
            {3'd4, 3'd3}: c = "t";
            {3'd4, 3'd4}: c = ";";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character that each entity stands for.
    function automatic logic [7:0] ent_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0: c = "<";
            3'd1: c = ">";
            3'd2: c = "&";
            3'd3: c = "'";
            3'd4: c = "\"";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Digit value with a valid flag in the top bit.
    function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - "0")};
        end else if (hex && b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - "a" + 8'd10)};
        end else if (hex && b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

### rtl/xml_text_unescape.sv
// XML character data unescaper: parse logic, result buffer and configuration register.
// Each accepted byte is decoded combinationally into a burst of 0 to 9 result transfers
// that are loaded into a result buffer and leave one per cycle while m_ready is high. A
// new byte is accepted when the buffer is empty or its last result leaves in that cycle,
// so plain text runs at one byte per cycle while m_ready is high; a byte with several results
// holds the input until its last leaves. The always-ready cfg channel writes the delimiter.
`include "assert_macros.svh"

module xml_text_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_start_run,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_status,
    output logic [3:0] m_pushback_count,
    output logic       m_last_result
);

    // Parse state and configuration.
    logic [7:0]  delim_reg;
    logic [2:0]  mode_reg, mode_next;
    logic [3:0]  pos_reg, pos_next;
    logic [4:0]  cand_reg, cand_next;
    logic [21:0] value_reg, value_next;
    logic        digit_reg, digit_next;
    logic [1:0]  bracket_reg, bracket_next;
    logic        cdata_reg, cdata_next;

    // Result buffer, shifted toward entry zero.
    xtu_pkg::result_t res_reg [xtu_pkg::MAX_RES];
    logic [3:0]       count_reg;

    // Working values of the decode logic.
    xtu_pkg::result_t lst [xtu_pkg::MAX_RES];
    logic [3:0]       n;
    logic [7:0]       b;
    logic [3:0]       pp;
    logic             stop;
    logic             do_text;
    logic             do_cdata;
    logic [4:0]       keep;
    logic             hit_ok;
    logic [2:0]       hit_k;
    logic [4:0]       dg;
    logic [25:0]      acc;
    logic [20:0]      v;

    logic in_xfer;
    logic out_xfer;

    // Appends one result to the list.
    function automatic void put(inout xtu_pkg::result_t l [xtu_pkg::MAX_RES],
                                inout logic [3:0] cnt, input logic [7:0] ob,
                                input logic [2:0] st, input logic [3:0] pb);
        if (cnt < 4'(xtu_pkg::MAX_RES)) begin
            l[cnt] = '{out_byte: ob, status: st, pushback: pb, last: 1'b0};
            cnt    = cnt + 4'd1;
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;
    assign out_xfer  = m_valid && m_ready;
    assign s_ready   = (count_reg == 4'd0) || (count_reg == 4'd1 && m_ready);
    assign b         = s_in_byte;

    // Decode of one input byte into its results and the next parse state.
    always_comb begin
        for (int i = 0; i < xtu_pkg::MAX_RES; i++) begin
            lst[i] = '0;
        end
        n            = 4'd0;
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        value_next   = value_reg;
        digit_next   = digit_reg;
        bracket_next = bracket_reg;
        cdata_next   = cdata_reg;
        pp           = 4'd1;
        stop         = 1'b0;
        do_text      = 1'b0;
        do_cdata     = 1'b0;
        keep         = 5'd0;
        hit_ok       = 1'b0;
        hit_k        = 3'd0;
        dg           = 5'd0;
        acc          = 26'd0;
        v            = 21'd0;

        if (s_start_run) begin
            mode_next    = xtu_pkg::MODE_NORMAL;
            pos_next     = 4'd0;
            cand_next    = 5'h1f;
            value_next   = 22'd0;
            digit_next   = 1'b0;
            bracket_next = 2'd0;
            cdata_next   = 1'b0;
        end

        case (mode_next)
            xtu_pkg::MODE_NORMAL: begin
                if (cdata_next) begin
                    do_cdata = 1'b1;
                end else begin
                    do_text = 1'b1;
                end
            end
            xtu_pkg::MODE_ENTITY: begin
                if (pos_next == 4'd0 && b == "#") begin
                    mode_next = xtu_pkg::MODE_REF_HASH;
                end else begin
                    for (int k = 0; k < xtu_pkg::NUM_ENT; k++) begin
                        if (cand_next[k] && pos_next < xtu_pkg::ent_len(3'(k))
                            && xtu_pkg::ent_name(3'(k), pos_next[2:0]) == b) begin
                            keep[k] = 1'b1;
                            if (pos_next + 4'd1 == xtu_pkg::ent_len(3'(k))) begin
                                hit_ok = 1'b1;
                                hit_k  = 3'(k);
                            end
                        end
                    end
                    if (keep == 5'd0) begin
                        put(lst, n, 8'd0, xtu_pkg::ST_BAD_ENT, 4'd0);
                        mode_next = xtu_pkg::MODE_DONE;
                    end else if (hit_ok) begin
                        put(lst, n, xtu_pkg::ent_char(hit_k), xtu_pkg::ST_BYTE, 4'd0);
                        mode_next = xtu_pkg::MODE_NORMAL;
                        pos_next  = 4'd0;
                        cand_next = 5'h1f;
                    end else begin
                        cand_next = keep;
                        pos_next  = pos_next + 4'd1;
                    end
                end
            end
            xtu_pkg::MODE_REF_HASH: begin
                dg = xtu_pkg::digit_of(b, 1'b0);
                if (dg[4]) begin
                    value_next = 22'(dg[3:0]);
                    digit_next = 1'b1;
                    mode_next  = xtu_pkg::MODE_REF_DEC;
                end else if (b == "x") begin
                    value_next = 22'd0;
                    digit_next = 1'b0;
                    mode_next  = xtu_pkg::MODE_REF_HEX;
                end else begin
                    put(lst, n, 8'd0, xtu_pkg::ST_BAD_REF, 4'd0);
                    mode_next = xtu_pkg::MODE_DONE;
                end
            end
            xtu_pkg::MODE_REF_DEC, xtu_pkg::MODE_REF_HEX: begin
                dg = xtu_pkg::digit_of(b, mode_next == xtu_pkg::MODE_REF_HEX);
                if (dg[4]) begin
                    // Accumulate with saturation at the range limit.
                    if (value_next < xtu_pkg::VALUE_LIMIT) begin
                        if (mode_next == xtu_pkg::MODE_REF_HEX) begin
                            acc = {value_next, 4'd0} + 26'(dg[3:0]);
                        end else begin
                            acc = {1'b0, value_next, 3'd0} + {3'd0, value_next, 1'b0}
                                + 26'(dg[3:0]);
                        end
                        if (acc > 26'(xtu_pkg::VALUE_LIMIT)) begin
                            value_next = xtu_pkg::VALUE_LIMIT;
                        end else begin
                            value_next = acc[21:0];
                        end
                    end else begin
                        value_next = xtu_pkg::VALUE_LIMIT;
                    end
                    digit_next = 1'b1;
                end else if (b == ";" && digit_next) begin
                    if (value_next >= xtu_pkg::VALUE_LIMIT) begin
                        put(lst, n, 8'd0, xtu_pkg::ST_RANGE, 4'd0);
                        mode_next = xtu_pkg::MODE_DONE;
                    end else begin
                        // UTF-8 encoding of the reference value.
                        v = value_next[20:0];
                        if (v < 21'h80) begin
                            put(lst, n, v[7:0], xtu_pkg::ST_BYTE, 4'd0);
                        end else if (v < 21'h800) begin
                            put(lst, n, {3'b110, v[10:6]}, xtu_pkg::ST_BYTE, 4'd0);
                            put(lst, n, {2'b10, v[5:0]}, xtu_pkg::ST_BYTE, 4'd0);
                        end else if (v < 21'h10000) begin
                            put(lst, n, {4'b1110, v[15:12]}, xtu_pkg::ST_BYTE, 4'd0);
                            put(lst, n, {2'b10, v[11:6]}, xtu_pkg::ST_BYTE, 4'd0);
                            put(lst, n, {2'b10, v[5:0]}, xtu_pkg::ST_BYTE, 4'd0);
                        end else begin
                            put(lst, n, {5'b11110, v[20:18]}, xtu_pkg::ST_BYTE, 4'd0);
                            put(lst, n, {2'b10, v[17:12]}, xtu_pkg::ST_BYTE, 4'd0);
                            put(lst, n, {2'b10, v[11:6]}, xtu_pkg::ST_BYTE, 4'd0);
                            put(lst, n, {2'b10, v[5:0]}, xtu_pkg::ST_BYTE, 4'd0);
                        end
                        mode_next  = xtu_pkg::MODE_NORMAL;
                        value_next = 22'd0;
                        digit_next = 1'b0;
                    end
                end else begin
                    put(lst, n, 8'd0, xtu_pkg::ST_BAD_REF, 4'd0);
                    mode_next = xtu_pkg::MODE_DONE;
                end
            end
            xtu_pkg::MODE_LOOKAHEAD: begin
                pp = pos_next;
                if (pp < 4'd1 || pp > 4'd8) begin
                    pp = 4'd1;
                end
                if (b == xtu_pkg::cdata_char(pp)) begin
                    if (pp + 4'd1 >= 4'(xtu_pkg::CDATA_LEN)) begin
                        cdata_next = 1'b1;
                        mode_next  = xtu_pkg::MODE_NORMAL;
                        pos_next   = 4'd0;
                    end else begin
                        pos_next = pp + 4'd1;
                    end
                end else begin
                    pos_next = 4'd0;
                    if (delim_reg == "<") begin
                        put(lst, n, 8'd0, xtu_pkg::ST_END, pp);
                        mode_next = xtu_pkg::MODE_DONE;
                    end else begin
                        // Replay the taken bytes as text; a delimiter among them ends the run.
                        mode_next = xtu_pkg::MODE_NORMAL;
                        put(lst, n, "<", xtu_pkg::ST_BYTE, 4'd0);
                        for (int i = 1; i < xtu_pkg::CDATA_LEN - 1; i++) begin
                            if (!stop && 4'(i) < pp) begin
                                if (xtu_pkg::cdata_char(4'(i)) == delim_reg) begin
                                    put(lst, n, 8'd0, xtu_pkg::ST_END, pp - 4'(i));
                                    mode_next = xtu_pkg::MODE_DONE;
                                    stop      = 1'b1;
                                end else begin
                                    put(lst, n, xtu_pkg::cdata_char(4'(i)),
                                        xtu_pkg::ST_BYTE, 4'd0);
                                end
                            end
                        end
                        do_text = !stop;
                    end
                end
            end
            default: begin
                mode_next = xtu_pkg::MODE_DONE;
            end
        endcase

        // Plain text byte.
        if (do_text) begin
            if (b == "]" && b != delim_reg) begin
                if (bracket_next < 2'd2) begin
                    bracket_next = bracket_next + 2'd1;
                end else begin
                    put(lst, n, "]", xtu_pkg::ST_BYTE, 4'd0);
                end
            end else if (bracket_next == 2'd2 && b == ">") begin
                bracket_next = 2'd0;
                put(lst, n, 8'd0, xtu_pkg::ST_STRAY, 4'd0);
                mode_next = xtu_pkg::MODE_DONE;
            end else begin
                if (bracket_next >= 2'd1) begin
                    put(lst, n, "]", xtu_pkg::ST_BYTE, 4'd0);
                end
                if (bracket_next == 2'd2) begin
                    put(lst, n, "]", xtu_pkg::ST_BYTE, 4'd0);
                end
                bracket_next = 2'd0;
                if (b == delim_reg) begin
                    if (delim_reg == "<") begin
                        mode_next = xtu_pkg::MODE_LOOKAHEAD;
                        pos_next  = 4'd1;
                    end else begin
                        put(lst, n, 8'd0, xtu_pkg::ST_END, 4'd0);
                        mode_next = xtu_pkg::MODE_DONE;
                    end
                end else if (b == 8'd0) begin
                    put(lst, n, 8'd0, xtu_pkg::ST_DATA_END, 4'd0);
                    mode_next = xtu_pkg::MODE_DONE;
                end else if (b == "<") begin
                    mode_next = xtu_pkg::MODE_LOOKAHEAD;
                    pos_next  = 4'd1;
                end else if (b == "&") begin
                    mode_next = xtu_pkg::MODE_ENTITY;
                    pos_next  = 4'd0;
                    cand_next = 5'h1f;
                end else begin
                    put(lst, n, b, xtu_pkg::ST_BYTE, 4'd0);
                end
            end
        end

        // Byte inside a CDATA section.
        if (do_cdata) begin
            if (b == "]") begin
                if (bracket_next < 2'd2) begin
                    bracket_next = bracket_next + 2'd1;
                end else begin
                    put(lst, n, "]", xtu_pkg::ST_BYTE, 4'd0);
                end
            end else if (b == ">" && bracket_next == 2'd2) begin
                bracket_next = 2'd0;
                cdata_next   = 1'b0;
            end else begin
                if (bracket_next >= 2'd1) begin
                    put(lst, n, "]", xtu_pkg::ST_BYTE, 4'd0);
                end
                if (bracket_next == 2'd2) begin
                    put(lst, n, "]", xtu_pkg::ST_BYTE, 4'd0);
                end
                bracket_next = 2'd0;
                if (b == 8'd0) begin
                    put(lst, n, 8'd0, xtu_pkg::ST_DATA_END, 4'd0);
                    mode_next = xtu_pkg::MODE_DONE;
                end else begin
                    put(lst, n, b, xtu_pkg::ST_BYTE, 4'd0);
                end
            end
        end

        // Flag the final result of this byte.
        if (n != 4'd0) begin
            lst[n - 4'd1].last = 1'b1;
        end
    end

    // Configuration register and parse state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg   <= xtu_pkg::DELIM_RESET;
            mode_reg    <= xtu_pkg::MODE_NORMAL;
            pos_reg     <= 4'd0;
            cand_reg    <= 5'h1f;
            value_reg   <= 22'd0;
            digit_reg   <= 1'b0;
            bracket_reg <= 2'd0;
            cdata_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                delim_reg <= cfg_data;
            end
            if (in_xfer) begin
                mode_reg    <= mode_next;
                pos_reg     <= pos_next;
                cand_reg    <= cand_next;
                value_reg   <= value_next;
                digit_reg   <= digit_next;
                bracket_reg <= bracket_next;
                cdata_reg   <= cdata_next;
            end
        end
    end

    // Result buffer: loaded on an input transfer, shifted on an output transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else if (in_xfer) begin
            count_reg <= n;
        end else if (out_xfer) begin
            count_reg <= count_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_reg <= lst;
        end else if (out_xfer) begin
            for (int i = 0; i < xtu_pkg::MAX_RES - 1; i++) begin
                res_reg[i] <= res_reg[i + 1];
            end
            res_reg[xtu_pkg::MAX_RES - 1] <= '0;
        end
    end

    assign m_valid          = (count_reg != 4'd0);
    assign m_out_byte       = res_reg[0].out_byte;
    assign m_status         = res_reg[0].status;
    assign m_pushback_count = res_reg[0].pushback;
    assign m_last_result    = res_reg[0].last;

    // The last flag marks exactly the final buffered result.
    `ASSERT_ALWAYS(a_last_flag, aclk, aresetn,
        !m_valid || (m_last_result == (count_reg == 4'd1)))
    // The buffer never holds more results than it has entries.
    `ASSERT_ALWAYS(a_count_max, aclk, aresetn, count_reg <= 4'(xtu_pkg::MAX_RES))
    // A finished run gives no results until a new run starts.
    `ASSERT_NEXT(a_done_silent, aclk, aresetn,
        in_xfer && !s_start_run && mode_reg == xtu_pkg::MODE_DONE, count_reg == 4'd0)
    // At most two brackets are ever held back.
    `ASSERT_ALWAYS(a_bracket_max, aclk, aresetn, bracket_reg != 2'd3)

endmodule

### bench/tb.sv
// Self-checking testbench for the XML character data unescaper.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 300;

    // One row of the directed table; a typed result is given where it is obvious.
    typedef struct {
        logic [7:0] in_byte;
        logic       start;
        logic       typed;
        logic [7:0] exp_byte;
        logic [2:0] exp_status;
        logic [3:0] exp_push;
    } row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_start_run;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic [2:0] m_status;
    logic [3:0] m_pushback_count;
    logic       m_last_result;

    xml_text_unescape u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_start_run      (s_start_run),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_status         (m_status),
        .m_pushback_count (m_pushback_count),
        .m_last_result    (m_last_result)
    );

    // Decoder state mirrored by the testbench.
    logic [7:0]  delim_q;
    logic [2:0]  mode_q;
    logic [3:0]  pos_q;
    logic [4:0]  cand_q;
    logic [21:0] refval_q;
    logic        has_digit_q;
    logic [1:0]  brackets_q;
    logic        in_cdata_q;

    xtu_pkg::result_t burst[$];
    xtu_pkg::result_t expected_out[$];
    logic [7:0] stim_byte[$];
    logic       stim_start[$];

    int  failures = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    bit  hold_req = 0;

    const logic [7:0] cdata_seq[9] = '{"<", "!", "[", "C", "D", "A", "T", "A", "["};
    const string      ent_names[5] = '{"lt;", "gt;", "amp;", "apos;", "quot;"};
    const logic [7:0] ent_chars[5] = '{"<", ">", "&", "'", "\""};

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- Decoder prediction ----------------

    function automatic void emit(logic [7:0] b, logic [2:0] st, logic [3:0] pb);
        xtu_pkg::result_t r;
        if (burst.size() >= xtu_pkg::MAX_RES) begin
            return;
        end
        r.out_byte = b;
        r.status = st;
        r.pushback = pb;
        r.last = 1'b0;
        burst.push_back(r);
    endfunction

    function automatic void close_run(logic [2:0] st, logic [3:0] pb);
        emit(8'h00, st, pb);
        mode_q = xtu_pkg::MODE_DONE;
    endfunction

    function automatic void clear_state();
        mode_q = xtu_pkg::MODE_NORMAL;
        pos_q = 4'd0;
        cand_q = 5'h1f;
        refval_q = 22'd0;
        has_digit_q = 1'b0;
        brackets_q = 2'd0;
        in_cdata_q = 1'b0;
    endfunction

    function automatic void release_brackets();
        while (brackets_q > 0) begin
            emit("]", xtu_pkg::ST_BYTE, 4'd0);
            brackets_q--;
        end
    endfunction

    function automatic void decode_text(logic [7:0] b);
        if (b == "]" && b != delim_q) begin
            if (brackets_q < 2) brackets_q++;
            else emit("]", xtu_pkg::ST_BYTE, 4'd0);
            return;
        end
        if (brackets_q == 2 && b == ">") begin
            brackets_q = 2'd0;
            close_run(xtu_pkg::ST_STRAY, 4'd0);
            return;
        end
        release_brackets();
        if (b == delim_q) begin
            if (delim_q == "<") begin
                mode_q = xtu_pkg::MODE_LOOKAHEAD;
                pos_q = 4'd1;
            end else begin
                close_run(xtu_pkg::ST_END, 4'd0);
            end
            return;
        end
        if (b == 8'h00) begin
            close_run(xtu_pkg::ST_DATA_END, 4'd0);
        end else if (b == "<") begin
            mode_q = xtu_pkg::MODE_LOOKAHEAD;
            pos_q = 4'd1;
        end else if (b == "&") begin
            mode_q = xtu_pkg::MODE_ENTITY;
            pos_q = 4'd0;
            cand_q = 5'h1f;
        end else begin
            emit(b, xtu_pkg::ST_BYTE, 4'd0);
        end
    endfunction

    function automatic void decode_cdata(logic [7:0] b);
        if (b == "]") begin
            if (brackets_q < 2) brackets_q++;
            else emit("]", xtu_pkg::ST_BYTE, 4'd0);
            return;
        end
        if (b == ">" && brackets_q == 2) begin
            brackets_q = 2'd0;
            in_cdata_q = 1'b0;
            return;
        end
        release_brackets();
        if (b == 8'h00) close_run(xtu_pkg::ST_DATA_END, 4'd0);
        else emit(b, xtu_pkg::ST_BYTE, 4'd0);
    endfunction

    function automatic void decode_lookahead(logic [7:0] b);
        logic [3:0] p;
        logic [7:0] replay[9];
        int n;
        p = pos_q;
        if (p < 1 || p > 8) p = 4'd1;
        if (b == cdata_seq[p]) begin
            p++;
            if (p >= 9) begin
                in_cdata_q = 1'b1;
                mode_q = xtu_pkg::MODE_NORMAL;
                pos_q = 4'd0;
            end else begin
                pos_q = p;
            end
            return;
        end
        pos_q = 4'd0;
        if (delim_q == "<") begin
            close_run(xtu_pkg::ST_END, p);
            return;
        end
        // The missed lookahead bytes are handled again as plain text.
        mode_q = xtu_pkg::MODE_NORMAL;
        emit("<", xtu_pkg::ST_BYTE, 4'd0);
        n = 0;
        for (int i = 1; i < p; i++) replay[n++] = cdata_seq[i];
        replay[n++] = b;
        for (int i = 0; i < n; i++) begin
            decode_text(replay[i]);
            if (mode_q == xtu_pkg::MODE_DONE) begin
                if (burst.size() > 0 && burst[burst.size() - 1].status == xtu_pkg::ST_END)
                    burst[burst.size() - 1].pushback = 4'(n - 1 - i);
                break;
            end
        end
    endfunction

    function automatic void decode_entity(logic [7:0] b);
        logic [4:0] keep;
        int hit;
        string nm;
        keep = 5'd0;
        hit = -1;
        if (pos_q == 0 && b == "#") begin
            mode_q = xtu_pkg::MODE_REF_HASH;
            return;
        end
        for (int k = 0; k < 5; k++) begin
            nm = ent_names[k];
            if (cand_q[k] && pos_q < nm.len() && nm[pos_q] == b) begin
                keep[k] = 1'b1;
                if (pos_q + 1 == nm.len()) hit = k;
            end
        end
        if (keep == 0) begin
            close_run(xtu_pkg::ST_BAD_ENT, 4'd0);
        end else if (hit >= 0) begin
            emit(ent_chars[hit], xtu_pkg::ST_BYTE, 4'd0);
            mode_q = xtu_pkg::MODE_NORMAL;
            pos_q = 4'd0;
            cand_q = 5'h1f;
        end else begin
            cand_q = keep;
            pos_q = pos_q + 4'd1;
        end
    endfunction

    // Returns the digit value, or -1 when the byte is no digit.
    function automatic int digit_value(logic [7:0] b, bit hex);
        if (b >= "0" && b <= "9") return b - "0";
        if (hex && b >= "a" && b <= "f") return b - "a" + 10;
        if (hex && b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic void encode_utf8();
        logic [31:0] v;
        v = refval_q;
        if (v >= xtu_pkg::VALUE_LIMIT) begin
            close_run(xtu_pkg::ST_RANGE, 4'd0);
            return;
        end
        if (v < 32'h80) begin
            emit(v[7:0], xtu_pkg::ST_BYTE, 4'd0);
        end else if (v < 32'h800) begin
            emit(8'hc0 | 8'(v >> 6), xtu_pkg::ST_BYTE, 4'd0);
            emit(8'h80 | 8'(v & 32'h3f), xtu_pkg::ST_BYTE, 4'd0);
        end else if (v < 32'h10000) begin
            emit(8'he0 | 8'(v >> 12), xtu_pkg::ST_BYTE, 4'd0);
            emit(8'h80 | 8'((v >> 6) & 32'h3f), xtu_pkg::ST_BYTE, 4'd0);
            emit(8'h80 | 8'(v & 32'h3f), xtu_pkg::ST_BYTE, 4'd0);
        end else begin
            emit(8'hf0 | 8'(v >> 18), xtu_pkg::ST_BYTE, 4'd0);
            emit(8'h80 | 8'((v >> 12) & 32'h3f), xtu_pkg::ST_BYTE, 4'd0);
            emit(8'h80 | 8'((v >> 6) & 32'h3f), xtu_pkg::ST_BYTE, 4'd0);
            emit(8'h80 | 8'(v & 32'h3f), xtu_pkg::ST_BYTE, 4'd0);
        end
        mode_q = xtu_pkg::MODE_NORMAL;
        refval_q = 22'd0;
        has_digit_q = 1'b0;
    endfunction

    function automatic void decode_reference(logic [7:0] b);
        bit hex;
        int dg;
        logic [31:0] v;
        hex = (mode_q == xtu_pkg::MODE_REF_HEX);
        if (mode_q == xtu_pkg::MODE_REF_HASH) begin
            dg = digit_value(b, 1'b0);
            if (dg >= 0) begin
                refval_q = 22'(dg);
                has_digit_q = 1'b1;
                mode_q = xtu_pkg::MODE_REF_DEC;
            end else if (b == "x") begin
                refval_q = 22'd0;
                has_digit_q = 1'b0;
                mode_q = xtu_pkg::MODE_REF_HEX;
            end else begin
                close_run(xtu_pkg::ST_BAD_REF, 4'd0);
            end
            return;
        end
        dg = digit_value(b, hex);
        if (dg >= 0) begin
            // The value saturates at the range limit.
            v = refval_q;
            if (v < xtu_pkg::VALUE_LIMIT) begin
                v = v * (hex ? 16 : 10) + dg;
                if (v > xtu_pkg::VALUE_LIMIT) v = xtu_pkg::VALUE_LIMIT;
            end else begin
                v = xtu_pkg::VALUE_LIMIT;
            end
            refval_q = 22'(v);
            has_digit_q = 1'b1;
        end else if (b == ";" && has_digit_q) begin
            encode_utf8();
        end else begin
            close_run(xtu_pkg::ST_BAD_REF, 4'd0);
        end
    endfunction

    // Computes the results of one accepted byte into the burst queue.
    function automatic void decode_byte(logic [7:0] b, logic start);
        burst.delete();
        if (start) clear_state();
        case (mode_q)
            xtu_pkg::MODE_NORMAL: begin
                if (in_cdata_q) decode_cdata(b);
                else decode_text(b);
            end
            xtu_pkg::MODE_ENTITY: decode_entity(b);
            xtu_pkg::MODE_REF_HASH, xtu_pkg::MODE_REF_DEC, xtu_pkg::MODE_REF_HEX:
                decode_reference(b);
            xtu_pkg::MODE_LOOKAHEAD: decode_lookahead(b);
            default: mode_q = xtu_pkg::MODE_DONE;
        endcase
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    endfunction

    // ---------------- Stimulus building ----------------

    task automatic add_byte(logic [7:0] b, logic s);
        stim_byte.push_back(b);
        stim_start.push_back(s);
    endtask

    task automatic add_text(string t);
        for (int i = 0; i < t.len(); i++) add_byte(t[i], 1'b0);
    endtask

    function automatic logic [21:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 22'($urandom_range(0, 32'h7f));
            1: return 22'($urandom_range(32'h80, 32'h7ff));
            2: return 22'($urandom_range(32'h800, 32'hffff));
            3: return 22'($urandom_range(32'h10000, 32'h1fffff));
            default: return 22'($urandom_range(32'h200000, 32'h3fffff));
        endcase
    endfunction

    // Builds text runs that are mostly well formed, with random content and some noise.
    task automatic build_runs(int count);
        int target;
        string t;
        target = stim_byte.size() + count;
        while (stim_byte.size() < target) begin
            add_byte(8'($urandom_range(32'h61, 32'h7a)), 1'b1);
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 9))
                    0: add_byte(8'($urandom_range(32'h20, 32'h7e)), 1'b0);
                    1: add_text({"&", ent_names[$urandom_range(0, 4)]});
                    2: begin
                        t = ent_names[$urandom_range(0, 4)];
                        add_text({"&", t.substr(0, $urandom_range(0, t.len() - 2))});
                        add_byte(8'($urandom_range(32'h20, 32'h7e)), 1'b0);
                    end
                    3: add_text($sformatf("&#%0d;", pick_value()));
                    4: begin
                        t = $sformatf("%0h", pick_value());
                        for (int i = 0; i < t.len(); i++) begin
                            if (t[i] >= "a" && $urandom_range(0, 1)) t[i] = t[i] - 8'h20;
                        end
                        add_text({"&#x", t, ";"});
                    end
                    5: begin
                        add_text("<![CDATA[");
                        repeat ($urandom_range(0, 6)) begin
                            if ($urandom_range(0, 2) == 0) add_byte("]", 1'b0);
                            else add_byte(8'($urandom_range(1, 255)), 1'b0);
                        end
                        add_text("]]>");
                    end
                    6: begin
                        repeat ($urandom_range(1, 4)) add_byte("]", 1'b0);
                        if ($urandom_range(0, 1)) add_byte(">", 1'b0);
                    end
                    7: begin
                        add_text($urandom_range(0, 1) ? "&#x" : "&#");
                        if ($urandom_range(0, 1)) add_byte("1", 1'b0);
                        add_byte($urandom_range(0, 1) ? ";" : "g", 1'b0);
                    end
                    8: begin
                        t = "<![CDATA[";
                        add_text(t.substr(0, $urandom_range(0, 7)));
                        add_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                    default: add_byte(8'($urandom_range(0, 255)), 1'b0);
                endcase
            end
            // End the run at the delimiter, with end of data, with a "<", or not at all.
            case ($urandom_range(0, 3))
                0: add_byte(delim_q, 1'b0);
                1: add_byte(8'h00, 1'b0);
                2: add_byte("<", 1'b0);
                default: ;
            endcase
            if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // ---------------- Driving ----------------

    // Offers one byte and waits for its transfer, then predicts its results.
    task automatic send_item(logic [7:0] b, logic s, bit typed, xtu_pkg::result_t typed_res);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_start_run <= s;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b, s);
        if (typed) expected_out.push_back(typed_res);
        else foreach (burst[i]) expected_out.push_back(burst[i]);
    endtask

    task automatic send_queued();
        xtu_pkg::result_t none;
        none = '0;
        while (stim_byte.size() > 0)
            send_item(stim_byte.pop_front(), stim_start.pop_front(), 0, none);
    endtask

    // Writes the delimiter once every expected result has left the block.
    task automatic write_delimiter(logic [7:0] d);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_out.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
        delim_q = d;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result receiver with random stalls and one long hold-off.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        xtu_pkg::result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                $error("unexpected result: byte %h status %0d", m_out_byte, m_status);
                failures++;
            end else begin
                e = expected_out.pop_front();
                if (m_out_byte !== e.out_byte) begin
                    $error("out_byte: expected %h, actual %h", e.out_byte, m_out_byte);
                    failures++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_status);
                    failures++;
                end
                if (m_pushback_count !== e.pushback) begin
                    $error("pushback_count: expected %0d, actual %0d", e.pushback,
                           m_pushback_count);
                    failures++;
                end
                if (m_last_result !== e.last) begin
                    $error("last_result: expected %0d, actual %0d", e.last, m_last_result);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Directed table: plain bytes, an entity, a four byte reference and three ways a run ends.
    row_t directed[] = '{
        '{"a",   1'b1, 1'b1, "a",   xtu_pkg::ST_BYTE,     4'd0},
        '{8'hff, 1'b0, 1'b1, 8'hff, xtu_pkg::ST_BYTE,     4'd0},
        '{"&",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"l",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"t",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{";",   1'b0, 1'b1, "<",   xtu_pkg::ST_BYTE,     4'd0},
        '{"&",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"#",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"x",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"1",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"F",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"6",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"0",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"0",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{";",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"]",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"]",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{">",   1'b0, 1'b1, 8'h00, xtu_pkg::ST_STRAY,    4'd0},
        '{"z",   1'b0, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{8'h00, 1'b1, 1'b1, 8'h00, xtu_pkg::ST_DATA_END, 4'd0},
        '{"<",   1'b1, 1'b0, 8'h00, xtu_pkg::ST_BYTE,     4'd0},
        '{"x",   1'b0, 1'b1, 8'h00, xtu_pkg::ST_END,      4'd1}
    };

    // Main sequence: reset, directed table, then random phases at several delimiters.
    initial begin
        xtu_pkg::result_t r;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 8'h00;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_start_run = 1'b0;
        delim_q = xtu_pkg::DELIM_RESET;
        clear_state();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            r.out_byte = directed[i].exp_byte;
            r.status = directed[i].exp_status;
            r.pushback = directed[i].exp_push;
            r.last = 1'b1;
            send_item(directed[i].in_byte, directed[i].start, directed[i].typed, r);
        end

        write_delimiter(8'hff);
        hold_req = 1;
        build_runs(30);
        send_queued();

        write_delimiter("\"");
        build_runs(35);
        send_queued();

        write_delimiter(8'h00);
        build_runs(30);
        send_queued();

        // Last part runs without idling on either side.
        write_delimiter(xtu_pkg::DELIM_RESET);
        quiet = 1;
        build_runs(70);
        send_queued();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_out.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/xtu_pkg.sv
rtl/xml_text_unescape.sv
bench/tb.sv
